// ----- sv/covalent_bond_detector_macros.svh -----
// Assertion macros shared by the bond detector RTL.
`ifndef COVALENT_BOND_DETECTOR_MACROS_SVH
`define COVALENT_BOND_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cbd_pkg.sv -----
// Shared types, constants and radius lookup for the covalent bond detector.
`timescale 1ns / 1ps
package cbd_pkg;

  localparam int CBD_MAX_ATOMS   = 64;
  localparam int CBD_QUEUE_DEPTH = 2;

  localparam int CBD_CODE_W    = 5;
  localparam int CBD_COORD_W   = 24;
  localparam int CBD_RAD_W     = 8;
  localparam int CBD_TOL_W     = 9;
  localparam int CBD_OUT_IDX_W = 6;

  localparam logic [CBD_TOL_W-1:0] CBD_TOL_RESET      = 9'd320;
  localparam logic [CBD_RAD_W-1:0] CBD_DEFAULT_RADIUS = 8'd76;

  // Covalent radii in units of 0.01 angstrom, indexed by element code
  localparam logic [CBD_RAD_W-1:0] CBD_RADIUS_TABLE [16] = '{
    8'd31,  8'd76,  8'd71,  8'd66,  8'd64,  8'd107, 8'd105, 8'd102,
    8'd120, 8'd139, 8'd154, 8'd196, 8'd130, 8'd176, 8'd132, 8'd122
  };

  typedef logic [CBD_COORD_W-1:0] cbd_coord_t;

  // Atom as it travels to and sits in the back end's store
  typedef struct packed {
    logic [CBD_RAD_W-1:0] radius;
    cbd_coord_t           x;
    cbd_coord_t           y;
    cbd_coord_t           z;
  } cbd_atom_t;

  // Codes with the top bit set are untabulated elements
  function automatic logic [CBD_RAD_W-1:0] cbd_radius(input logic [CBD_CODE_W-1:0] code);
    logic [CBD_RAD_W-1:0] r;
    if (code[CBD_CODE_W-1]) begin
      r = CBD_DEFAULT_RADIUS;
    end else begin
      r = CBD_RADIUS_TABLE[code[CBD_CODE_W-2:0]];
    end
    return r;
  endfunction

endpackage

// ----- sv/cbd_front.sv -----
// Front end: accepts atoms, assigns store indices, flags overflow, looks up radii.
`timescale 1ns / 1ps
module cbd_front #(
  parameter int  MAX_ATOMS = cbd_pkg::CBD_MAX_ATOMS,
  localparam int IDX_W     = $clog2(MAX_ATOMS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_start_new,
  input  logic [cbd_pkg::CBD_CODE_W-1:0]   in_element_code,
  input  cbd_pkg::cbd_coord_t              in_x_pos,
  input  cbd_pkg::cbd_coord_t              in_y_pos,
  input  cbd_pkg::cbd_coord_t              in_z_pos,
  input  logic                             cmd_full,
  output logic                             cmd_push,
  output logic                             cmd_ovf,
  output logic [IDX_W-1:0]                 cmd_idx,
  output cbd_pkg::cbd_atom_t               cmd_atom
);
  import cbd_pkg::*;

  localparam int CNT_W = $clog2(MAX_ATOMS + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Take an item whenever the queue has room
  assign in_stall = cmd_full;
  assign cmd_push = in_valid && !cmd_full;

  // Classify: start clears the store, a full store drops the atom
  always_comb begin
    cmd_ovf = !in_start_new && (count_r == CNT_W'(MAX_ATOMS));
    cmd_idx = in_start_new ? '0 : count_r[IDX_W-1:0];
    cmd_atom.radius = cbd_radius(in_element_code);
    cmd_atom.x      = in_x_pos;
    cmd_atom.y      = in_y_pos;
    cmd_atom.z      = in_z_pos;
  end

  // Advance the fill count for every stored atom
  always_comb begin
    count_nxt = count_r;
    if (cmd_push && !cmd_ovf) begin
      count_nxt = CNT_W'(cmd_idx) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/cbd_queue.sv -----
// Small command queue between the front and back ends.
`timescale 1ns / 1ps
module cbd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cbd_pkg::CBD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);
  import cbd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Wrap pointers and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store payload, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/cbd_back.sv -----
// Back end: scans the atom store, tests each pair, and emits bond items.
`timescale 1ns / 1ps
module cbd_back #(
  parameter int  MAX_ATOMS = cbd_pkg::CBD_MAX_ATOMS,
  localparam int IDX_W     = $clog2(MAX_ATOMS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cbd_pkg::CBD_TOL_W-1:0]     tolerance,
  input  logic                              cmd_valid,
  output logic                              cmd_pop,
  input  logic                              cmd_ovf,
  input  logic [IDX_W-1:0]                  cmd_idx,
  input  cbd_pkg::cbd_atom_t                cmd_atom,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cbd_pkg::CBD_OUT_IDX_W-1:0] out_lower_index,
  output logic [cbd_pkg::CBD_OUT_IDX_W-1:0] out_upper_index,
  output logic                              out_overflow,
  output logic                              out_last_of_run
);
  import cbd_pkg::*;

  // Any axis gap of 2^NEAR_W or more exceeds the largest bond limit
  localparam int NEAR_W  = 11;
  localparam int SQ_W    = 2 * NEAR_W;
  localparam int D2_W    = SQ_W + 2;
  localparam int SCALE_W = 14;
  localparam int LHS_W   = D2_W + SCALE_W;
  localparam int RSUM_W  = CBD_RAD_W + 1;
  localparam int LIM_W   = RSUM_W + CBD_TOL_W;
  localparam int RHS_W   = 2 * LIM_W;
  localparam logic [SCALE_W-1:0] DIST_SCALE = 14'd10000;

  typedef struct packed {
    logic valid;
    logic tail;
    logic ovf;
  } tok_t;

  function automatic logic [CBD_COORD_W:0] abs_diff(input cbd_coord_t a, input cbd_coord_t b);
    logic [CBD_COORD_W:0] d;
    d = {a[CBD_COORD_W-1], a} - {b[CBD_COORD_W-1], b};
    return d[CBD_COORD_W] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic [CBD_OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W+CBD_OUT_IDX_W-1:0] t;
    t = {{CBD_OUT_IDX_W{1'b0}}, v};
    return t[CBD_OUT_IDX_W-1:0];
  endfunction

  logic adv, issue, is_tail;
  logic [IDX_W-1:0] j_r, j_nxt;

  cbd_atom_t mem_r [MAX_ATOMS];
  cbd_atom_t rd_r;

  tok_t             s1_tok_r, s2_tok_r, s3_tok_r, s4_tok_r;
  logic [IDX_W-1:0] s1_j_r, s2_j_r, s3_j_r, s4_j_r;
  logic [IDX_W-1:0] s1_up_r, s2_up_r, s3_up_r, s4_up_r;
  cbd_atom_t        s1_atom_r;

  logic [CBD_COORD_W:0] ad_x, ad_y, ad_z;
  logic                 s1_far;
  logic [RSUM_W-1:0]    s1_rsum;
  logic                 s2_far_r, s3_far_r, s4_far_r;
  logic [NEAR_W-1:0]    s2_dx_r, s2_dy_r, s2_dz_r;
  logic [RSUM_W-1:0]    s2_rsum_r;
  logic [SQ_W-1:0]      s3_sqx_r, s3_sqy_r, s3_sqz_r;
  logic [LIM_W-1:0]     s3_lim_r;
  logic [D2_W-1:0]      s3_d2;
  logic [LHS_W-1:0]     s4_lhs_r;
  logic [RHS_W-1:0]     s4_rhs_r;
  logic                 bonded;

  logic                     pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]         pend_j_r, pend_j_nxt;
  logic [IDX_W-1:0]         pend_up_r, pend_up_nxt;
  logic                     push;
  logic [IDX_W-1:0]         push_lo, push_up;
  logic                     push_ovf, push_last;

  logic                     out_valid_r;
  logic [CBD_OUT_IDX_W-1:0] out_lower_r, out_upper_r;
  logic                     out_ovf_r, out_last_r;

  // The whole scan pipeline moves only when the output register can take an item
  assign adv     = !out_valid_r || !out_stall;
  assign issue   = adv && cmd_valid;
  assign is_tail = cmd_ovf || (j_r == cmd_idx);
  assign cmd_pop = issue && is_tail;

  // Step the scan address; the closing slot of each atom retires the command
  always_comb begin
    j_nxt = j_r;
    if (issue) begin
      j_nxt = is_tail ? '0 : j_r + IDX_W'(1);
    end
  end

  // Store the new atom on its closing slot; read the scanned entry registered
  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd_ovf) begin
      mem_r[cmd_idx] <= cmd_atom;
    end
    if (adv) begin
      rd_r <= mem_r[j_r];
    end
  end

  // Stage 1: axis gaps and radius sum
  always_comb begin
    ad_x    = abs_diff(s1_atom_r.x, rd_r.x);
    ad_y    = abs_diff(s1_atom_r.y, rd_r.y);
    ad_z    = abs_diff(s1_atom_r.z, rd_r.z);
    s1_far  = (|ad_x[CBD_COORD_W:NEAR_W]) || (|ad_y[CBD_COORD_W:NEAR_W])
              || (|ad_z[CBD_COORD_W:NEAR_W]);
    s1_rsum = RSUM_W'(rd_r.radius) + RSUM_W'(s1_atom_r.radius);
  end

  // Stage 3: squared distance
  assign s3_d2 = D2_W'(s3_sqx_r) + D2_W'(s3_sqy_r) + D2_W'(s3_sqz_r);

  // Stage 4: bond test on exact integers
  assign bonded = !s4_far_r && (s4_lhs_r <= LHS_W'(s4_rhs_r));

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r      <= '0;
      s1_tok_r <= '0;
      s2_tok_r <= '0;
      s3_tok_r <= '0;
      s4_tok_r <= '0;
    end else begin
      j_r <= j_nxt;
      if (adv) begin
        s1_tok_r <= '{valid: cmd_valid, tail: is_tail, ovf: cmd_ovf};
        s2_tok_r <= s1_tok_r;
        s3_tok_r <= s2_tok_r;
        s4_tok_r <= s3_tok_r;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_j_r    <= j_r;
      s1_up_r   <= cmd_idx;
      s1_atom_r <= cmd_atom;

      s2_j_r    <= s1_j_r;
      s2_up_r   <= s1_up_r;
      s2_far_r  <= s1_far;
      s2_dx_r   <= ad_x[NEAR_W-1:0];
      s2_dy_r   <= ad_y[NEAR_W-1:0];
      s2_dz_r   <= ad_z[NEAR_W-1:0];
      s2_rsum_r <= s1_rsum;

      s3_j_r    <= s2_j_r;
      s3_up_r   <= s2_up_r;
      s3_far_r  <= s2_far_r;
      s3_sqx_r  <= SQ_W'(s2_dx_r) * SQ_W'(s2_dx_r);
      s3_sqy_r  <= SQ_W'(s2_dy_r) * SQ_W'(s2_dy_r);
      s3_sqz_r  <= SQ_W'(s2_dz_r) * SQ_W'(s2_dz_r);
      s3_lim_r  <= LIM_W'(s2_rsum_r) * LIM_W'(tolerance);

      s4_j_r    <= s3_j_r;
      s4_up_r   <= s3_up_r;
      s4_far_r  <= s3_far_r;
      s4_lhs_r  <= LHS_W'(s3_d2) * LHS_W'(DIST_SCALE);
      s4_rhs_r  <= RHS_W'(s3_lim_r) * RHS_W'(s3_lim_r);
    end
  end

  // Hold the latest bond back until the next one or the closing slot decides its last flag
  always_comb begin
    push        = 1'b0;
    push_lo     = pend_j_r;
    push_up     = pend_up_r;
    push_ovf    = 1'b0;
    push_last   = 1'b0;
    pend_v_nxt  = pend_v_r;
    pend_j_nxt  = pend_j_r;
    pend_up_nxt = pend_up_r;
    if (s4_tok_r.valid) begin
      priority if (s4_tok_r.ovf) begin
        push      = 1'b1;
        push_lo   = '0;
        push_up   = '0;
        push_ovf  = 1'b1;
        push_last = 1'b1;
      end else if (s4_tok_r.tail) begin
        push       = pend_v_r;
        push_last  = 1'b1;
        pend_v_nxt = 1'b0;
      end else if (bonded) begin
        push        = pend_v_r;
        pend_v_nxt  = 1'b1;
        pend_j_nxt  = s4_j_r;
        pend_up_nxt = s4_up_r;
      end else begin
        // Drop a slot without a bond
        push = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pend_j_r  <= pend_j_nxt;
      pend_up_r <= pend_up_nxt;
      if (push) begin
        out_lower_r <= out_idx(push_lo);
        out_upper_r <= out_idx(push_up);
        out_ovf_r   <= push_ovf;
        out_last_r  <= push_last;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lower_index = out_lower_r;
  assign out_upper_index = out_upper_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_of_run = out_last_r;

endmodule

// ----- sv/covalent_bond_detector.sv -----
// Top level of the covalent bond detector: front end, command queue, back end.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid / in_stall, atom fields        | input
//   out     | out_valid / out_stall, bond fields      | output
//   cfg     | cfg_wr_en, cfg_wr_data (tolerance_q8)   | input
//
// The back end does one store read per earlier atom plus a closing slot for an atom;
// a dropped atom takes only its closing slot. No slot issues while a stalled output
// holds an item. A bond item is registered out when the next bond or the closing slot
// of its atom is in stage 4; an overflow item, when its own slot is in stage 4.
// Reset is synchronous; the store needs no clearing pass, as the fill count resets.
// out_stall freezes the scan pipeline; the front queue keeps taking items until full.
`timescale 1ns / 1ps
`include "covalent_bond_detector_macros.svh"
module covalent_bond_detector #(
  parameter int MAX_ATOMS = cbd_pkg::CBD_MAX_ATOMS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [cbd_pkg::CBD_TOL_W-1:0]     cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_start_new,
  input  logic [cbd_pkg::CBD_CODE_W-1:0]    in_element_code,
  input  cbd_pkg::cbd_coord_t               in_x_pos,
  input  cbd_pkg::cbd_coord_t               in_y_pos,
  input  cbd_pkg::cbd_coord_t               in_z_pos,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cbd_pkg::CBD_OUT_IDX_W-1:0] out_lower_index,
  output logic [cbd_pkg::CBD_OUT_IDX_W-1:0] out_upper_index,
  output logic                              out_overflow,
  output logic                              out_last_of_run
);
  import cbd_pkg::*;

  localparam int IDX_W = $clog2(MAX_ATOMS);
  localparam int CMD_W = 1 + IDX_W + $bits(cbd_atom_t);

  logic [CBD_TOL_W-1:0] tol_r;

  logic             f_push, f_ovf;
  logic [IDX_W-1:0] f_idx;
  cbd_atom_t        f_atom;

  logic             q_full, q_valid, q_pop;
  logic [CMD_W-1:0] q_head;
  logic             b_ovf;
  logic [IDX_W-1:0] b_idx;
  cbd_atom_t        b_atom;

  logic             ovf_item_ok;

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= CBD_TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  cbd_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_new    (in_start_new),
    .in_element_code (in_element_code),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_z_pos        (in_z_pos),
    .cmd_full        (q_full),
    .cmd_push        (f_push),
    .cmd_ovf         (f_ovf),
    .cmd_idx         (f_idx),
    .cmd_atom        (f_atom)
  );

  cbd_queue #(.WIDTH(CMD_W), .DEPTH(CBD_QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_ovf, f_idx, f_atom}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign {b_ovf, b_idx, b_atom} = q_head;

  cbd_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .tolerance       (tol_r),
    .cmd_valid       (q_valid),
    .cmd_pop         (q_pop),
    .cmd_ovf         (b_ovf),
    .cmd_idx         (b_idx),
    .cmd_atom        (b_atom),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lower_index (out_lower_index),
    .out_upper_index (out_upper_index),
    .out_overflow    (out_overflow),
    .out_last_of_run (out_last_of_run)
  );

  // An overflow item closes its atom's run and carries zero indices
  assign ovf_item_ok = out_last_of_run && (out_lower_index == '0) && (out_upper_index == '0);
  `CBD_ASSERT_NOW(a_ovf_format, out_valid && out_overflow, ovf_item_ok, "bad overflow item")
  // A full queue always offers a command to the back end
  `CBD_ASSERT_NOW(a_full_has_head, in_stall, q_valid, "queue full without head")
  // A queued command stays until the back end retires it
  `CBD_ASSERT_NEXT(a_head_holds, q_valid && !q_pop, q_valid, "queued command lost")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the covalent bond detector: directed cases, then random molecules.
`timescale 1ns / 1ps
module testbench;
  import cbd_pkg::*;

  localparam int          CLK_HALF_NS    = 5;
  localparam int          RESET_CYCLES   = 7;
  localparam longint      RUN_LIMIT_NS   = 10_000_000;
  localparam int          IDLE_LIMIT     = 40_000;
  localparam int          SETTLE_CYCLES  = (CBD_QUEUE_DEPTH + 2) * (CBD_MAX_ATOMS + 1) + 16;
  localparam int          PRESSURE_HOLD  = 400;
  localparam logic [63:0] RADIUS_SCALE_SQ = 64'd10000;

  // Element codes used by the directed cases
  localparam logic [CBD_CODE_W-1:0] EL_H     = 5'd0;
  localparam logic [CBD_CODE_W-1:0] EL_C     = 5'd1;
  localparam logic [CBD_CODE_W-1:0] EL_O     = 5'd3;
  localparam logic [CBD_CODE_W-1:0] EL_K     = 5'd11;
  localparam logic [CBD_CODE_W-1:0] EL_FE    = 5'd14;
  localparam logic [CBD_CODE_W-1:0] EL_ZN    = 5'd15;
  localparam logic [CBD_CODE_W-1:0] EL_OTHER = 5'd16;
  localparam logic [CBD_CODE_W-1:0] EL_TOP   = 5'd31;

  localparam cbd_coord_t COORD_MAX = 24'h7FFFFF;
  localparam cbd_coord_t COORD_MIN = 24'h800000;

  typedef struct packed {
    logic [CBD_OUT_IDX_W-1:0] lower;
    logic [CBD_OUT_IDX_W-1:0] upper;
    logic                     overflow;
    logic                     last;
  } bond_item_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CBD_TOL_W-1:0]     cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_start_new;
  logic [CBD_CODE_W-1:0]    in_element_code;
  cbd_coord_t               in_x_pos;
  cbd_coord_t               in_y_pos;
  cbd_coord_t               in_z_pos;
  logic                     out_valid;
  logic                     out_stall;
  logic [CBD_OUT_IDX_W-1:0] out_lower_index;
  logic [CBD_OUT_IDX_W-1:0] out_upper_index;
  logic                     out_overflow;
  logic                     out_last_of_run;

  // Predictor state: stored atoms and the current tolerance
  logic [CBD_TOL_W-1:0]  tolerance_now;
  int                    atom_total;
  logic [CBD_CODE_W-1:0] stored_code [CBD_MAX_ATOMS];
  cbd_coord_t            stored_x [CBD_MAX_ATOMS];
  cbd_coord_t            stored_y [CBD_MAX_ATOMS];
  cbd_coord_t            stored_z [CBD_MAX_ATOMS];
  bond_item_t            pending_bonds [$];
  bond_item_t            want_bond;

  // Sender and receiver pacing
  int burst_left;
  int gap_max;
  int stall_pct;
  int stall_run;
  int hold_left;
  bit stall_now;

  // Run statistics
  int mismatches;
  int atoms_sent;
  int runs_started;
  int bonds_checked;
  int overflows_checked;
  int tolerance_writes;

  covalent_bond_detector DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_new    (in_start_new),
    .in_element_code (in_element_code),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_z_pos        (in_z_pos),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lower_index (out_lower_index),
    .out_upper_index (out_upper_index),
    .out_overflow    (out_overflow),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF_NS);
    clk = 1'b1;
    #(CLK_HALF_NS);
  end

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Radius in 1/100 angstrom; untabulated codes take the default
  function automatic int unsigned covalent_radius(input logic [CBD_CODE_W-1:0] code);
    if (code < 16) begin
      return int'(CBD_RADIUS_TABLE[code[3:0]]);
    end
    return int'(CBD_DEFAULT_RADIUS);
  endfunction

  function automatic logic [63:0] axis_square(input cbd_coord_t a, input cbd_coord_t b);
    logic signed [CBD_COORD_W:0] d;
    logic [CBD_COORD_W:0]        m;
    d = $signed({a[CBD_COORD_W-1], a}) - $signed({b[CBD_COORD_W-1], b});
    m = d[CBD_COORD_W] ? -d : d;
    return 64'(m) * 64'(m);
  endfunction

  function automatic cbd_coord_t jitter(input cbd_coord_t base, input int spread);
    int off;
    off = $urandom_range(0, 2 * spread) - spread;
    return base + 24'(off);
  endfunction

  // Work out the bond items that one accepted atom causes, then store the atom
  task automatic predict_bonds(input bit start, input logic [CBD_CODE_W-1:0] code,
                               input cbd_coord_t x, input cbd_coord_t y, input cbd_coord_t z);
    logic [63:0] reach;
    logic [63:0] dist2;
    bond_item_t  found [$];
    bond_item_t  hit;
    if (start) begin
      atom_total = 0;
    end
    if (atom_total >= CBD_MAX_ATOMS) begin
      // Drop the atom: one overflow item, indices zero
      hit = '{lower: '0, upper: '0, overflow: 1'b1, last: 1'b1};
      pending_bonds.push_back(hit);
    end else begin
      for (int j = 0; j < atom_total; j++) begin
        reach = 64'(covalent_radius(stored_code[j]) + covalent_radius(code))
              * 64'(tolerance_now);
        dist2 = axis_square(x, stored_x[j]) + axis_square(y, stored_y[j])
              + axis_square(z, stored_z[j]);
        if (dist2 * RADIUS_SCALE_SQ <= reach * reach) begin
          hit = '{lower: 6'(j), upper: 6'(atom_total), overflow: 1'b0, last: 1'b0};
          found.push_back(hit);
        end
      end
      if (found.size() > 0) begin
        found[found.size() - 1].last = 1'b1;
      end
      pending_bonds = {pending_bonds, found};
      stored_code[atom_total] = code;
      stored_x[atom_total]    = x;
      stored_y[atom_total]    = y;
      stored_z[atom_total]    = z;
      atom_total++;
    end
  endtask

  // Offer one atom in bursts with random gaps; return once it is accepted
  task automatic send_atom(input bit start, input logic [CBD_CODE_W-1:0] code,
                           input cbd_coord_t x, input cbd_coord_t y, input cbd_coord_t z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_start_new    <= start;
    in_element_code <= code;
    in_x_pos        <= x;
    in_y_pos        <= y;
    in_z_pos        <= z;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_bonds(start, code, x, y, z);
    atoms_sent++;
    if (start) begin
      runs_started++;
    end
  endtask

  task automatic set_tolerance(input logic [CBD_TOL_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tolerance_now = value;
    tolerance_writes++;
  endtask

  // Stop sending, let every expected item arrive, then let the back end settle
  task automatic wait_idle();
    int saved_pct;
    int n;
    saved_pct = stall_pct;
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    stall_pct  = 0;
    n = 0;
    while ((pending_bonds.size() != 0 || hold_left != 0) && n < IDLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_bonds.size() != 0) begin
      report_error($sformatf("%0d expected items never arrived", pending_bonds.size()));
      pending_bonds.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    stall_pct = saved_pct;
  endtask

  // Receiver pattern: stall or flow for short random stretches, or hold off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_now = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      stall_run = $urandom_range(0, 5);
      out_stall <= stall_now;
    end
  end

  // Check each accepted item against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bonds.size() == 0) begin
        report_error($sformatf("item %0d-%0d ovf=%0b with nothing expected",
                               out_lower_index, out_upper_index, out_overflow));
      end else begin
        want_bond = pending_bonds.pop_front();
        if (out_lower_index !== want_bond.lower) begin
          report_error($sformatf("lower_index got %0d want %0d",
                                 out_lower_index, want_bond.lower));
        end
        if (out_upper_index !== want_bond.upper) begin
          report_error($sformatf("upper_index got %0d want %0d",
                                 out_upper_index, want_bond.upper));
        end
        if (out_overflow !== want_bond.overflow) begin
          report_error($sformatf("overflow got %0b want %0b",
                                 out_overflow, want_bond.overflow));
        end
        if (out_last_of_run !== want_bond.last) begin
          report_error($sformatf("last_of_run got %0b want %0b",
                                 out_last_of_run, want_bond.last));
        end
        if (want_bond.overflow) begin
          overflows_checked++;
        end else begin
          bonds_checked++;
        end
      end
    end
  end

  // Reset tolerance: first atom, a plain bond, isolated atoms, untabulated codes
  task automatic test_default_tolerance();
    gap_max   = 2;
    stall_pct = 20;
    send_atom(1'b1, EL_H, 24'd0, 24'd0, 24'd0);
    send_atom(1'b0, EL_C, 24'd256, 24'd0, 24'd0);
    send_atom(1'b0, EL_O, 24'd5000, 24'd5000, 24'd0);
    send_atom(1'b0, EL_OTHER, 24'd256, 24'd300, 24'd0);
    send_atom(1'b0, EL_TOP, 24'd5000, 24'd5200, 24'd100);
    wait_idle();
  endtask

  // Hydrogen pair just inside and just outside the bond distance at tolerance 1.0
  task automatic test_bond_threshold();
    set_tolerance(9'd256);
    send_atom(1'b1, EL_H, 24'd0, 24'd0, 24'd0);
    send_atom(1'b0, EL_H, 24'd158, 24'd0, 24'd0);
    send_atom(1'b1, EL_H, 24'd0, 24'd0, 24'd0);
    send_atom(1'b0, EL_H, 24'(-159), 24'd0, 24'd0);
    wait_idle();
  endtask

  // Zero tolerance bonds only coincident atoms
  task automatic test_zero_tolerance();
    set_tolerance(9'd0);
    send_atom(1'b1, EL_H, 24'd5, 24'd5, 24'd5);
    send_atom(1'b0, EL_FE, 24'd5, 24'd5, 24'd5);
    send_atom(1'b0, EL_ZN, 24'd5, 24'd5, 24'd6);
    send_atom(1'b0, EL_TOP, 24'd5, 24'd5, 24'd5);
    wait_idle();
  endtask

  // Corners of the coordinate range at the widest tolerance
  task automatic test_extreme_coordinates();
    set_tolerance(9'd511);
    send_atom(1'b1, EL_ZN, COORD_MAX, COORD_MAX, COORD_MAX);
    send_atom(1'b0, EL_FE, COORD_MIN, COORD_MIN, COORD_MIN);
    send_atom(1'b0, EL_K, COORD_MAX, COORD_MAX, COORD_MAX);
    send_atom(1'b0, EL_OTHER, COORD_MIN, COORD_MIN, COORD_MIN);
    send_atom(1'b0, EL_TOP, COORD_MAX, COORD_MIN, 24'd0);
    wait_idle();
  endtask

  // Fill the store, bond the top index to index 0, drop atoms past capacity, restart
  task automatic test_full_store();
    set_tolerance(CBD_TOL_RESET);
    gap_max   = 3;
    stall_pct = 20;
    for (int i = 0; i < CBD_MAX_ATOMS - 1; i++) begin
      send_atom(i == 0, EL_C, 24'(i * 4096 - 131072), 24'd1000, 24'(-1000));
    end
    send_atom(1'b0, EL_C, 24'(-131072 + 200), 24'd1000, 24'(-1000));
    send_atom(1'b0, EL_H, 24'd0, 24'd0, 24'd0);
    send_atom(1'b0, EL_H, 24'd0, 24'd0, 24'd0);
    send_atom(1'b1, EL_C, 24'd0, 24'd0, 24'd0);
    send_atom(1'b0, EL_H, 24'd200, 24'd0, 24'd0);
    wait_idle();
  endtask

  // Hold the receiver off while a dense cluster streams in, so the block backs up
  task automatic test_output_backpressure();
    cbd_coord_t cx;
    cbd_coord_t cy;
    cbd_coord_t cz;
    cx = 24'($urandom);
    cy = 24'($urandom);
    cz = 24'($urandom);
    gap_max   = 0;
    stall_pct = 0;
    hold_left = PRESSURE_HOLD;
    for (int k = 0; k < 16; k++) begin
      send_atom(k == 0, EL_C, jitter(cx, 150), jitter(cy, 150), jitter(cz, 150));
    end
    wait_idle();
  endtask

  // Mostly clustered molecules with random content, some stray atoms and unbroken stores
  task automatic test_random_molecules(input int item_goal, input logic [CBD_TOL_W-1:0] tol,
                                       input int gaps, input int stalls);
    int                    sent;
    int                    run_len;
    int                    spread;
    bit                    carry_on;
    logic [CBD_CODE_W-1:0] code;
    cbd_coord_t            cx;
    cbd_coord_t            cy;
    cbd_coord_t            cz;
    set_tolerance(tol);
    gap_max   = gaps;
    stall_pct = stalls;
    sent      = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 9) == 0) begin
        run_len = $urandom_range(40, 70);
        spread  = 4000;
      end else begin
        run_len = $urandom_range(2, 12);
        case ($urandom_range(0, 2))
          0:       spread = 150;
          1:       spread = 400;
          default: spread = 1200;
        endcase
      end
      carry_on = ($urandom_range(0, 7) == 0);
      cx = 24'($urandom);
      cy = 24'($urandom);
      cz = 24'($urandom);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_atom(k == 0 && !carry_on, 5'($urandom_range(0, 31)),
                    24'($urandom), 24'($urandom), 24'($urandom));
        end else begin
          code = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 16))
                                            : 5'($urandom_range(17, 31));
          send_atom(k == 0 && !carry_on, code,
                    jitter(cx, spread), jitter(cy, spread), jitter(cz, spread));
        end
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_start_new    = 1'b0;
    in_element_code = '0;
    in_x_pos        = '0;
    in_y_pos        = '0;
    in_z_pos        = '0;
    out_stall       = 1'b0;
    tolerance_now   = CBD_TOL_RESET;
    atom_total      = 0;
    burst_left      = 0;
    gap_max         = 0;
    stall_pct       = 0;
    stall_run       = 0;
    hold_left       = 0;
    mismatches        = 0;
    atoms_sent        = 0;
    runs_started      = 0;
    bonds_checked     = 0;
    overflows_checked = 0;
    tolerance_writes  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_default_tolerance();
    test_bond_threshold();
    test_zero_tolerance();
    test_extreme_coordinates();
    test_full_store();
    test_output_backpressure();
    test_random_molecules(45, 9'($urandom_range(256, 511)), 4, 30);
    test_random_molecules(30, 9'd511, 0, 0);
    test_random_molecules(30, 9'($urandom_range(0, 511)), 70, 60);
    test_random_molecules(25, CBD_TOL_RESET, 10, 15);

    $display("Covered %0d atoms in %0d fresh stores over %0d tolerance writes.",
             atoms_sent, runs_started, tolerance_writes);
    $display("Checked %0d bond items and %0d full-store drops; mismatches: %0d.",
             bonds_checked, overflows_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d items still expected", pending_bonds.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
